[rtl/mcbi_pkg.sv]
package mcbi_pkg;

    localparam int SAMPLE_BITS_DEF  = 24;
    localparam int CORDIC_STEPS_DEF = 24;

    localparam logic [31:0] PI_HALF_Q30 = 32'd1686629713;
    localparam logic [31:0] ONE_Q30     = 32'd1073741824;
    localparam logic [33:0] GAIN_Q30    = 34'd652032874;
    localparam logic [47:0] PI2_8_Q28   = 48'd331168970;

    localparam logic [15:0] SPB_RESET = 16'd1000;
    localparam logic [15:0] NB_RESET  = 16'd100;

    typedef enum logic [0:0] {
        REG_SAMPLES_PER_BLOCK = 1'b0,
        REG_NUM_BLOCKS        = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic [23:0] uniform_a;
        logic [23:0] uniform_b;
    } t_sample;

    typedef struct packed {
        logic [15:0] block_number;
        logic [31:0] mean_plain;
        logic [30:0] error_plain;
        logic [31:0] mean_importance;
        logic [30:0] error_importance;
    } t_result;

    // Arctangent of 2^-i in Q2.30 radians.
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            5'd24:   v = 32'h0000003F;
            5'd25:   v = 32'h0000001F;
            5'd26:   v = 32'h0000000F;
            5'd27:   v = 32'h00000008;
            5'd28:   v = 32'h00000004;
            5'd29:   v = 32'h00000002;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

[rtl/mcbi_if.sv]
interface mcbi_in_if;
    logic              valid;
    logic              ready;
    mcbi_pkg::t_sample data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mcbi_out_if;
    logic              valid;
    logic              ready;
    mcbi_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/monte_carlo_block_integrator_core.sv]
// Monte Carlo integrator with blocking. Each input word carries two Q0.24 uniform samples;
// the block takes one word at a time and is not ready while it works. For a sample word,
// two iterative CORDIC cosines, a 32-step bit-serial square root and a 64-step bit-serial
// divide run one after another. The word that closes a block spends most of its extra
// time in the shared divider (averages, running means, mean squares and the variance
// division) and the error square roots. One result word per completed block leaves
// through an output register, so a waiting result does not stop the next sample word.
module monte_carlo_block_integrator_core #(
    parameter int SAMPLE_BITS  = mcbi_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STEPS = mcbi_pkg::CORDIC_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    mcbi_in_if.sink           i_sample,
    mcbi_out_if.source        o_result
);

    localparam int NS = 26;

    typedef enum logic [NS-1:0] {
        ST_IDLE     = NS'(1) << 0,
        ST_ANG_A    = NS'(1) << 1,
        ST_COR_A_GO = NS'(1) << 2,
        ST_COR_A    = NS'(1) << 3,
        ST_FA       = NS'(1) << 4,
        ST_SQRT     = NS'(1) << 5,
        ST_XQ       = NS'(1) << 6,
        ST_COR_B_GO = NS'(1) << 7,
        ST_COR_B    = NS'(1) << 8,
        ST_FX       = NS'(1) << 9,
        ST_TERM_DIV = NS'(1) << 10,
        ST_ACC      = NS'(1) << 11,
        ST_AVG_DIV  = NS'(1) << 12,
        ST_SQ_LO    = NS'(1) << 13,
        ST_SQ_HI    = NS'(1) << 14,
        ST_SQ_ADD   = NS'(1) << 15,
        ST_MEAN_DIV = NS'(1) << 16,
        ST_MSQ_DIV  = NS'(1) << 17,
        ST_M2_LO    = NS'(1) << 18,
        ST_M2_HI    = NS'(1) << 19,
        ST_VAR      = NS'(1) << 20,
        ST_ERR_DIV  = NS'(1) << 21,
        ST_ERR_SQRT = NS'(1) << 22,
        ST_EMIT     = NS'(1) << 23,
        ST_SPARE_A  = NS'(1) << 24,
        ST_SPARE_B  = NS'(1) << 25
    } t_state;

    t_state r_state;

    // Configuration and block state.
    logic [15:0] r_spb, r_nb, r_cnt, r_bc;
    logic        r_fin;
    logic [47:0] r_acc_p, r_acc_i, r_tm_p, r_tm_i;
    logic [63:0] r_tsq_p, r_tsq_i;

    // Per-word working registers.
    logic [23:0] r_ua, r_ub;
    logic [31:0] r_fa, r_s;
    logic [47:0] r_term, r_avg, r_mean;
    logic [63:0] r_tmp, r_msq;
    logic        r_est;
    logic [31:0] r_mean_p;
    logic [30:0] r_err_p, r_err_i;

    logic              r_out_valid;
    mcbi_pkg::t_result r_out_data;

    // Shared multiplier, registered.
    logic [31:0] mul_a, mul_b;
    logic [63:0] r_prod;

    // Shared divider: 64-bit dividend, 32-bit divisor, one quotient bit per cycle.
    logic        div_start, r_div_busy;
    logic [63:0] div_num, r_div_q;
    logic [31:0] div_den, r_div_den, r_div_rem;
    logic [5:0]  r_div_cnt;
    logic [32:0] div_rem_sh;

    // Shared square root: 64-bit radicand, one root bit per cycle.
    logic        sqrt_start, r_sq_busy;
    logic [63:0] sqrt_rad, r_sq_rad;
    logic [34:0] r_sq_rem, sq_rem_sh, sq_trial;
    logic [31:0] r_sq_root;
    logic [4:0]  r_sq_cnt;

    // CORDIC rotator.
    logic               cor_start, r_cor_busy;
    logic [33:0]        cor_theta;
    logic signed [33:0] r_cor_x, r_cor_y, r_cor_z, cor_dx, cor_dy, cor_at;
    logic [4:0]         r_cor_i;

    // Derived values.
    logic [31:0] ua_m, ub_m, smask, x_clamp, xq, f_val;
    logic [63:0] f_sum, rad_b, term_num, sq_full, sq_round, m2, var_v;
    logic [15:0] n_cnt, spb_eff, n_bc;
    logic        blk_end;
    logic [47:0] n_acc_p, n_acc_i;
    logic        accept;

    assign accept         = i_sample.valid && i_sample.ready;
    assign i_sample.ready = (r_state == ST_IDLE);
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_data;

    assign smask    = 32'((64'd1 << SAMPLE_BITS) - 64'd1);
    assign ua_m     = {8'd0, r_ua} & smask;
    assign ub_m     = {8'd0, r_ub} & smask;
    assign rad_b    = ((64'd1 << SAMPLE_BITS) - {32'd0, ub_m}) << (60 - SAMPLE_BITS);
    assign x_clamp  = r_cor_x[33] ? 32'd0 : r_cor_x[31:0];
    assign f_sum    = r_prod + 64'h8000_0000;
    assign f_val    = f_sum[63:32];
    assign xq       = mcbi_pkg::ONE_Q30 - ((r_s > mcbi_pkg::ONE_Q30) ? mcbi_pkg::ONE_Q30 : r_s);
    assign term_num = ({32'd0, f_val} << 29) + {33'd0, r_s[31:1]};
    assign n_cnt    = r_cnt + 16'd1;
    assign spb_eff  = (r_spb == 16'd0) ? 16'd1 : r_spb;
    assign blk_end  = !(n_cnt < spb_eff);
    assign n_acc_p  = r_acc_p + {16'd0, r_fa};
    assign n_acc_i  = r_acc_i + r_term;
    assign n_bc     = r_bc + 16'd1;
    // Low 64 bits of a 48-bit square from two 32-bit products.
    assign sq_full  = r_tmp + {r_prod[30:0], 33'd0};
    assign sq_round = sq_full + 64'h8000;
    assign m2       = sq_full;
    assign var_v    = (r_msq > m2) ? (r_msq - m2) : 64'd0;

    assign div_rem_sh = {r_div_rem, r_div_q[63]};
    assign sq_rem_sh  = {r_sq_rem[32:0], r_sq_rad[63:62]};
    assign sq_trial   = {1'b0, r_sq_root, 2'b01};
    assign cor_dx     = r_cor_y >>> r_cor_i;
    assign cor_dy     = r_cor_x >>> r_cor_i;
    assign cor_at     = $signed({2'b00, mcbi_pkg::atan_q30(r_cor_i)});

    always_comb begin
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        sqrt_start = 1'b0;
        sqrt_rad   = '0;
        cor_start  = 1'b0;
        cor_theta  = '0;
        case (r_state)
            ST_ANG_A: begin
                mul_a = ua_m;
                mul_b = mcbi_pkg::PI_HALF_Q30;
            end
            ST_COR_A_GO: begin
                cor_start = 1'b1;
                cor_theta = 34'(r_prod >> SAMPLE_BITS);
            end
            ST_COR_A, ST_COR_B: begin
                mul_a = x_clamp;
                mul_b = mcbi_pkg::PI_HALF_Q30;
            end
            ST_FA: begin
                sqrt_start = 1'b1;
                sqrt_rad   = rad_b;
            end
            ST_XQ: begin
                mul_a = xq;
                mul_b = mcbi_pkg::PI_HALF_Q30;
            end
            ST_COR_B_GO: begin
                cor_start = 1'b1;
                cor_theta = 34'(r_prod >> 30);
            end
            ST_FX: begin
                if (r_s != 32'd0) begin
                    div_start = 1'b1;
                    div_num   = term_num;
                    div_den   = r_s;
                end
            end
            ST_ACC: begin
                if (blk_end) begin
                    div_start = 1'b1;
                    div_num   = {16'd0, n_acc_p} + {49'd0, n_cnt[15:1]};
                    div_den   = {16'd0, n_cnt};
                end
            end
            ST_SQ_LO: begin
                mul_a = r_avg[31:0];
                mul_b = r_avg[31:0];
            end
            ST_SQ_HI: begin
                mul_a = {16'd0, r_avg[47:32]};
                mul_b = r_avg[31:0];
            end
            ST_SQ_ADD: begin
                div_start = 1'b1;
                if (!r_est) begin
                    div_num = {16'd0, r_acc_i} + {49'd0, n_cnt[15:1]};
                    div_den = {16'd0, n_cnt};
                end else begin
                    div_num = {16'd0, r_tm_p} + {49'd0, n_bc[15:1]};
                    div_den = {16'd0, n_bc};
                end
            end
            ST_MEAN_DIV: begin
                if (!r_div_busy) begin
                    div_start = 1'b1;
                    div_num   = r_est ? r_tsq_i : r_tsq_p;
                    div_den   = {16'd0, r_bc};
                end
            end
            ST_M2_LO: begin
                mul_a = r_mean[31:0];
                mul_b = r_mean[31:0];
            end
            ST_M2_HI: begin
                mul_a = {16'd0, r_mean[47:32]};
                mul_b = r_mean[31:0];
            end
            ST_VAR: begin
                div_start = 1'b1;
                div_num   = var_v;
                div_den   = {16'd0, r_bc};
            end
            ST_ERR_DIV: begin
                if (!r_div_busy) begin
                    sqrt_start = 1'b1;
                    sqrt_rad   = r_div_q;
                end
            end
            ST_ERR_SQRT: begin
                if (!r_sq_busy && !r_est) begin
                    div_start = 1'b1;
                    div_num   = {16'd0, r_tm_i} + {49'd0, r_bc[15:1]};
                    div_den   = {16'd0, r_bc};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= {32'd0, mul_a} * {32'd0, mul_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
        end else if (div_start) begin
            r_div_busy <= 1'b1;
            r_div_cnt  <= '0;
            r_div_q    <= div_num;
            r_div_rem  <= '0;
            r_div_den  <= div_den;
        end else if (r_div_busy) begin
            if (div_rem_sh >= {1'b0, r_div_den}) begin
                r_div_rem <= 32'(div_rem_sh - {1'b0, r_div_den});
                r_div_q   <= {r_div_q[62:0], 1'b1};
            end else begin
                r_div_rem <= div_rem_sh[31:0];
                r_div_q   <= {r_div_q[62:0], 1'b0};
            end
            r_div_cnt <= r_div_cnt + 6'd1;
            if (r_div_cnt == 6'd63) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_busy <= 1'b0;
            r_sq_cnt  <= '0;
        end else if (sqrt_start) begin
            r_sq_busy <= 1'b1;
            r_sq_cnt  <= '0;
            r_sq_rad  <= sqrt_rad;
            r_sq_rem  <= '0;
            r_sq_root <= '0;
        end else if (r_sq_busy) begin
            if (sq_rem_sh >= sq_trial) begin
                r_sq_rem  <= sq_rem_sh - sq_trial;
                r_sq_root <= {r_sq_root[30:0], 1'b1};
            end else begin
                r_sq_rem  <= sq_rem_sh;
                r_sq_root <= {r_sq_root[30:0], 1'b0};
            end
            r_sq_rad <= {r_sq_rad[61:0], 2'b00};
            r_sq_cnt <= r_sq_cnt + 5'd1;
            if (r_sq_cnt == 5'd31) begin
                r_sq_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cor_busy <= 1'b0;
            r_cor_i    <= '0;
        end else if (cor_start) begin
            r_cor_busy <= 1'b1;
            r_cor_i    <= '0;
            r_cor_x    <= $signed(mcbi_pkg::GAIN_Q30);
            r_cor_y    <= '0;
            r_cor_z    <= $signed(cor_theta);
        end else if (r_cor_busy) begin
            if (!r_cor_z[33]) begin
                r_cor_x <= r_cor_x - cor_dx;
                r_cor_y <= r_cor_y + cor_dy;
                r_cor_z <= r_cor_z - cor_at;
            end else begin
                r_cor_x <= r_cor_x + cor_dx;
                r_cor_y <= r_cor_y - cor_dy;
                r_cor_z <= r_cor_z + cor_at;
            end
            r_cor_i <= r_cor_i + 5'd1;
            if (r_cor_i == 5'(CORDIC_STEPS - 1)) begin
                r_cor_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_spb       <= mcbi_pkg::SPB_RESET;
            r_nb        <= mcbi_pkg::NB_RESET;
            r_cnt       <= '0;
            r_bc        <= '0;
            r_fin       <= 1'b0;
            r_acc_p     <= '0;
            r_acc_i     <= '0;
            r_tm_p      <= '0;
            r_tm_i      <= '0;
            r_tsq_p     <= '0;
            r_tsq_i     <= '0;
            r_est       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mcbi_pkg::REG_SAMPLES_PER_BLOCK: r_spb <= i_cfg_data;
                    mcbi_pkg::REG_NUM_BLOCKS:        r_nb  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (r_fin || (r_bc >= r_nb)) begin
                            r_fin <= 1'b1;
                        end else begin
                            r_ua    <= i_sample.data.uniform_a;
                            r_ub    <= i_sample.data.uniform_b;
                            r_state <= ST_ANG_A;
                        end
                    end
                end
                ST_ANG_A:    r_state <= ST_COR_A_GO;
                ST_COR_A_GO: r_state <= ST_COR_A;
                ST_COR_A: begin
                    if (!r_cor_busy) begin
                        r_state <= ST_FA;
                    end
                end
                ST_FA: begin
                    r_fa    <= f_val;
                    r_state <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (!r_sq_busy) begin
                        r_s     <= r_sq_root;
                        r_state <= ST_XQ;
                    end
                end
                ST_XQ:       r_state <= ST_COR_B_GO;
                ST_COR_B_GO: r_state <= ST_COR_B;
                ST_COR_B: begin
                    if (!r_cor_busy) begin
                        r_state <= ST_FX;
                    end
                end
                ST_FX: begin
                    // A zero root takes the limit of f(x)/(2(1-x)) as x goes to one.
                    if (r_s == 32'd0) begin
                        r_term  <= mcbi_pkg::PI2_8_Q28;
                        r_state <= ST_ACC;
                    end else begin
                        r_state <= ST_TERM_DIV;
                    end
                end
                ST_TERM_DIV: begin
                    if (!r_div_busy) begin
                        r_term  <= r_div_q[47:0];
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    r_acc_p <= n_acc_p;
                    r_acc_i <= n_acc_i;
                    if (blk_end) begin
                        r_est   <= 1'b0;
                        r_state <= ST_AVG_DIV;
                    end else begin
                        r_cnt   <= n_cnt;
                        r_state <= ST_IDLE;
                    end
                end
                ST_AVG_DIV: begin
                    if (!r_div_busy) begin
                        r_avg   <= r_div_q[47:0];
                        r_state <= ST_SQ_LO;
                    end
                end
                ST_SQ_LO: r_state <= ST_SQ_HI;
                ST_SQ_HI: begin
                    r_tmp   <= r_prod;
                    r_state <= ST_SQ_ADD;
                end
                ST_SQ_ADD: begin
                    if (!r_est) begin
                        r_tm_p  <= r_tm_p + r_avg;
                        r_tsq_p <= r_tsq_p + {16'd0, sq_round[63:16]};
                        r_est   <= 1'b1;
                        r_state <= ST_AVG_DIV;
                    end else begin
                        r_tm_i  <= r_tm_i + r_avg;
                        r_tsq_i <= r_tsq_i + {16'd0, sq_round[63:16]};
                        r_acc_p <= '0;
                        r_acc_i <= '0;
                        r_cnt   <= '0;
                        r_bc    <= n_bc;
                        if (n_bc >= r_nb) begin
                            r_fin <= 1'b1;
                        end
                        r_est   <= 1'b0;
                        r_state <= ST_MEAN_DIV;
                    end
                end
                ST_MEAN_DIV: begin
                    if (!r_div_busy) begin
                        r_mean  <= r_div_q[47:0];
                        r_state <= ST_MSQ_DIV;
                    end
                end
                ST_MSQ_DIV: begin
                    if (!r_div_busy) begin
                        r_msq   <= {r_div_q[47:0], 16'd0};
                        r_state <= ST_M2_LO;
                    end
                end
                ST_M2_LO: r_state <= ST_M2_HI;
                ST_M2_HI: begin
                    r_tmp   <= r_prod;
                    r_state <= ST_VAR;
                end
                ST_VAR: r_state <= ST_ERR_DIV;
                ST_ERR_DIV: begin
                    if (!r_div_busy) begin
                        r_state <= ST_ERR_SQRT;
                    end
                end
                ST_ERR_SQRT: begin
                    if (!r_sq_busy) begin
                        if (!r_est) begin
                            r_mean_p <= r_mean[31:0];
                            r_err_p  <= r_sq_root[30:0];
                            r_est    <= 1'b1;
                            r_state  <= ST_MEAN_DIV;
                        end else begin
                            r_err_i <= r_sq_root[30:0];
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid                 <= 1'b1;
                        r_out_data.block_number     <= r_bc;
                        r_out_data.mean_plain       <= r_mean_p;
                        r_out_data.error_plain      <= r_err_p;
                        r_out_data.mean_importance  <= r_mean[31:0];
                        r_out_data.error_importance <= r_err_i;
                        r_est                       <= 1'b0;
                        r_state                     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

[rtl/mcbi_checker.sv]
module mcbi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_block_number
);

    // A result word waits until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // Reset leaves no result word pending.
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result word valid after reset");

    // A new result word is only produced at the end of a busy stretch.
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result word appeared while sampler was idle");

    // Block numbers count from one.
    a_block_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_block_number != 16'd0)
        else $error("block number zero in result word");

endmodule

bind monte_carlo_block_integrator_core mcbi_checker u_mcbi_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_sample.ready),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_block_number (o_result.data.block_number)
);
